>>> design/brf_pkg.sv
`default_nettype none
package brf_pkg;

	localparam int LANES = 8;
	localparam int CAP_W = 13;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_BLOCKED = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] burst_length;
		logic [7:0] wdata_0;
		logic [7:0] wdata_1;
		logic [7:0] wdata_2;
		logic [7:0] wdata_3;
		logic [7:0] wdata_4;
		logic [7:0] wdata_5;
		logic [7:0] wdata_6;
		logic [7:0] wdata_7;
	} in_item_t;

	typedef struct packed {
		logic             status;
		logic [7:0]       rdata_0;
		logic [7:0]       rdata_1;
		logic [7:0]       rdata_2;
		logic [7:0]       rdata_3;
		logic [7:0]       rdata_4;
		logic [7:0]       rdata_5;
		logic [7:0]       rdata_6;
		logic [7:0]       rdata_7;
		logic [CAP_W-1:0] fill_level;
		logic [CAP_W-1:0] free_space;
	} res_item_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_WRITE,
		FSM_READ,
		FSM_TAIL,
		FSM_RESP
	} fsm_t;

endpackage
`default_nettype wire

>>> design/brf_ram.sv
`default_nettype none
module brf_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/brf_ctrl.sv
`default_nettype none
module brf_ctrl import brf_pkg::*; #(
	parameter int DEPTH       = 4096,
	parameter int BURST_LANES = 8,
	parameter int AW          = 12,
	parameter int CW          = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire in_item_t         item,
	output logic                  done,
	output res_item_t             result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data,
	output logic                  ram_we,
	output logic      [AW-1:0]    ram_waddr,
	output logic      [7:0]       ram_wdata,
	output logic                  ram_re,
	output logic      [AW-1:0]    ram_raddr,
	input  wire logic [7:0]       ram_rdata
);

	localparam int SW      = (CW > CAP_W) ? CW : CAP_W;
	localparam int CAP_RAW = DEPTH % (1 << CAP_W);
	localparam int CAP_RST = (CAP_RAW == 0) ? 1 : CAP_RAW;

	fsm_t state_q, state_d;

	logic [CW-1:0] cap_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [3:0]    len_q;
	logic [2:0]    lane_q;
	logic          status_q;
	logic [7:0]    wdata_q [LANES];
	logic [7:0]    rdata_q [LANES];
	logic          rd_en_s1;
	logic [2:0]    rd_lane_s1;

	logic          accept;
	logic [3:0]    len;
	logic [SW-1:0] free_w;
	logic [SW-1:0] cap_clamp;
	logic [CW-1:0] wr_ptr_inc;
	logic [CW-1:0] rd_ptr_inc;
	logic          last_lane;
	logic          go_write;
	logic          go_read;
	logic          refuse;

	assign accept    = start && !busy;
	// capacity is taken only between commands
	assign cfg_ready = !busy && !start;
	assign len       = (item.burst_length > 4'(BURST_LANES)) ? 4'(BURST_LANES)
		: item.burst_length;
	assign free_w    = SW'(cap_q) - SW'(fill_q);
	assign last_lane = (lane_q == 3'(len_q - 4'd1));

	assign wr_ptr_inc = CW'(wr_ptr_q) + CW'(1);
	assign rd_ptr_inc = CW'(rd_ptr_q) + CW'(1);

	// zero acts as one slot, anything above the memory acts as the memory
	always_comb begin
		cap_clamp = SW'(cfg_data);
		if (cap_clamp == '0) begin
			cap_clamp = SW'(1);
		end else if (cap_clamp > SW'(DEPTH)) begin
			cap_clamp = SW'(DEPTH);
		end
	end

	always_comb begin
		go_write = 1'b0;
		go_read  = 1'b0;
		refuse   = 1'b0;
		if (len != 4'd0) begin
			case (item.operation)
				OP_WRITE: begin
					if (free_w < SW'(len)) refuse = 1'b1;
					else go_write = 1'b1;
				end
				OP_READ: begin
					if (SW'(fill_q) < SW'(len)) refuse = 1'b1;
					else go_read = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_raddr = rd_ptr_q;
		ram_wdata = wdata_q[lane_q];
		case (state_q)
			FSM_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (go_write) state_d = FSM_WRITE;
					else if (go_read) state_d = FSM_READ;
					else state_d = FSM_RESP;
				end
			end
			FSM_WRITE: begin
				ram_we = 1'b1;
				if (last_lane) state_d = FSM_RESP;
			end
			FSM_READ: begin
				ram_re = 1'b1;
				if (last_lane) state_d = FSM_TAIL;
			end
			FSM_TAIL: begin
				state_d = FSM_RESP;
			end
			FSM_RESP: begin
				done    = 1'b1;
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CW'(CAP_RST);
			fill_q     <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			lane_q     <= '0;
			len_q      <= '0;
			rd_en_s1   <= 1'b0;
			rd_lane_s1 <= '0;
		end else begin
			rd_en_s1   <= ram_re;
			rd_lane_s1 <= lane_q;
			if (cfg_valid && cfg_ready) begin
				// new capacity drops whatever was counted as stored
				cap_q    <= CW'(cap_clamp);
				fill_q   <= '0;
				wr_ptr_q <= '0;
				rd_ptr_q <= '0;
			end else begin
				case (state_q)
					FSM_IDLE: begin
						lane_q <= '0;
						len_q  <= len;
						if (accept && item.operation == OP_CLEAR) begin
							fill_q   <= '0;
							wr_ptr_q <= '0;
							rd_ptr_q <= '0;
						end
					end
					FSM_WRITE: begin
						lane_q   <= lane_q + 3'd1;
						wr_ptr_q <= (wr_ptr_inc == cap_q) ? '0 : AW'(wr_ptr_inc);
						if (last_lane) fill_q <= fill_q + CW'(len_q);
					end
					FSM_READ: begin
						lane_q   <= lane_q + 3'd1;
						rd_ptr_q <= (rd_ptr_inc == cap_q) ? '0 : AW'(rd_ptr_inc);
					end
					FSM_TAIL: begin
						fill_q <= fill_q - CW'(len_q);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= refuse ? ST_BLOCKED : ST_DONE;
			wdata_q[0] <= item.wdata_0;
			wdata_q[1] <= item.wdata_1;
			wdata_q[2] <= item.wdata_2;
			wdata_q[3] <= item.wdata_3;
			wdata_q[4] <= item.wdata_4;
			wdata_q[5] <= item.wdata_5;
			wdata_q[6] <= item.wdata_6;
			wdata_q[7] <= item.wdata_7;
			for (int i = 0; i < LANES; i++) begin
				rdata_q[i] <= '0;
			end
		end else if (rd_en_s1) begin
			rdata_q[rd_lane_s1] <= ram_rdata;
		end
	end

	always_comb begin
		result.status     = status_q;
		result.rdata_0    = rdata_q[0];
		result.rdata_1    = rdata_q[1];
		result.rdata_2    = rdata_q[2];
		result.rdata_3    = rdata_q[3];
		result.rdata_4    = rdata_q[4];
		result.rdata_5    = rdata_q[5];
		result.rdata_6    = rdata_q[6];
		result.rdata_7    = rdata_q[7];
		result.fill_level = CAP_W'(fill_q);
		result.free_space = CAP_W'(cap_q - fill_q);
	end

endmodule
`default_nettype wire

>>> design/byte_ring_fifo_burst_top.sv
`default_nettype none
// byte ring fifo, bursts of up to eight bytes, one byte memory access a cycle
// throughput: one command at a time, the next start is taken when busy falls
// the single-port-per-direction byte memory sets the one-byte-per-cycle pace
// results are strobed on done for one cycle; the receiver cannot stall
// reset: pointers and fill cleared, capacity set to the memory depth
module byte_ring_fifo_burst_top import brf_pkg::*; #(
	parameter int DEPTH       = 4096,
	parameter int BURST_LANES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// command side: a transfer is start while busy is low
	input  wire logic             start,
	output logic                  busy,
	input  wire in_item_t         item,
	// result side: one transfer per command, marked by done
	output logic                  done,
	output res_item_t             result,
	// capacity register write
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	// pointer width and the width of a fill count up to the full depth
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// sequencer: checks space or data, walks the burst lanes, keeps pointers
	brf_ctrl #(
		.DEPTH       (DEPTH),
		.BURST_LANES (BURST_LANES),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// byte store, contents undefined until written; only counted bytes are read
	brf_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

>>> tb/tb_byte_ring_fifo_burst_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_byte_ring_fifo_burst_top;
	import brf_pkg::*;

	localparam int RING_DEPTH   = 4096;
	localparam int STALL_LIMIT  = 20000;
	localparam int GAP_PCT      = 13;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	in_item_t          item      = '0;
	logic              cfg_valid = 1'b0;
	logic [CAP_W-1:0]  cfg_data  = '0;
	logic              busy;
	logic              done;
	res_item_t         result;
	logic              cfg_ready;

	// commands not yet presented, and reports still owed by the block
	in_item_t          bursts_waiting [$];
	res_item_t         reports_due [$];
	res_item_t         want;

	// shadow of the ring: store, pointers, full flag and capacity register
	logic [7:0]        ring_mem [RING_DEPTH];
	int unsigned       wr_ptr;
	int unsigned       rd_ptr;
	bit                ring_full;
	logic [CAP_W-1:0]  cap_reg;

	int unsigned       n_sent;
	int unsigned       mismatch_count;
	int unsigned       quiet_cycles;
	bit                no_gaps;

	byte_ring_fifo_burst_top #(
		.DEPTH       (RING_DEPTH),
		.BURST_LANES (LANES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bytes currently held, given the number of slots in use
	function automatic int unsigned ring_fill(int unsigned slots_n);
		if (ring_full)
			return slots_n;
		if (wr_ptr >= rd_ptr)
			return wr_ptr - rd_ptr;
		return slots_n + wr_ptr - rd_ptr;
	endfunction

	// applies one command to the shadow ring and returns the report it earns
	function automatic res_item_t ring_apply(in_item_t cmd);
		int unsigned slots_n;
		int unsigned nbytes;
		int unsigned fill;
		logic [7:0]  lanes_in [LANES];
		logic [7:0]  lanes_out [LANES];
		res_item_t   r;
		// capacity of zero behaves as one slot, anything past the memory as full depth
		if (cap_reg == 0)
			slots_n = 1;
		else if (cap_reg > RING_DEPTH)
			slots_n = RING_DEPTH;
		else
			slots_n = cap_reg;
		// lengths past the lane count saturate
		nbytes = (cmd.burst_length > LANES) ? LANES : cmd.burst_length;
		lanes_in = '{cmd.wdata_0, cmd.wdata_1, cmd.wdata_2, cmd.wdata_3,
			cmd.wdata_4, cmd.wdata_5, cmd.wdata_6, cmd.wdata_7};
		foreach (lanes_out[i])
			lanes_out[i] = '0;
		r = '0;
		r.status = ST_DONE;
		wr_ptr = wr_ptr % slots_n;
		rd_ptr = rd_ptr % slots_n;
		fill = ring_fill(slots_n);
		case (cmd.operation)
		OP_CLEAR: begin
			wr_ptr = 0;
			rd_ptr = 0;
			ring_full = 1'b0;
		end
		OP_WRITE: begin
			// whole burst or nothing
			if (nbytes != 0 && slots_n - fill < nbytes) begin
				r.status = ST_BLOCKED;
			end else if (nbytes != 0) begin
				for (int i = 0; i < nbytes; i++) begin
					ring_mem[wr_ptr] = lanes_in[i];
					wr_ptr = (wr_ptr + 1 == slots_n) ? 0 : wr_ptr + 1;
				end
				ring_full = (wr_ptr == rd_ptr);
			end
		end
		OP_READ: begin
			if (nbytes != 0 && fill < nbytes) begin
				r.status = ST_BLOCKED;
			end else if (nbytes != 0) begin
				for (int i = 0; i < nbytes; i++) begin
					lanes_out[i] = ring_mem[rd_ptr];
					rd_ptr = (rd_ptr + 1 == slots_n) ? 0 : rd_ptr + 1;
				end
				ring_full = 1'b0;
			end
		end
		default: ;	// spare opcode is a no-op
		endcase
		fill = ring_fill(slots_n);
		r.rdata_0 = lanes_out[0];
		r.rdata_1 = lanes_out[1];
		r.rdata_2 = lanes_out[2];
		r.rdata_3 = lanes_out[3];
		r.rdata_4 = lanes_out[4];
		r.rdata_5 = lanes_out[5];
		r.rdata_6 = lanes_out[6];
		r.rdata_7 = lanes_out[7];
		r.fill_level = CAP_W'(fill);
		r.free_space = CAP_W'(slots_n - fill);
		return r;
	endfunction

	// lanes get distinct bytes so a swapped lane shows up
	function automatic in_item_t make_burst(logic [1:0] op, logic [3:0] len, logic [7:0] b);
		in_item_t c;
		c.operation = op;
		c.burst_length = len;
		c.wdata_0 = b;
		c.wdata_1 = b ^ 8'h11;
		c.wdata_2 = b ^ 8'h22;
		c.wdata_3 = b ^ 8'h33;
		c.wdata_4 = b ^ 8'h44;
		c.wdata_5 = b ^ 8'h55;
		c.wdata_6 = b ^ 8'h66;
		c.wdata_7 = b ^ 8'h77;
		return c;
	endfunction

	// mostly sane bursts, a few empty, over-long, clear or spare-opcode commands
	function automatic in_item_t random_burst();
		in_item_t c;
		int unsigned p;
		int unsigned q;
		logic [95:0] raw;
		p = $urandom_range(0, 99);
		q = $urandom_range(0, 99);
		raw = {$urandom, $urandom, $urandom};
		c = raw[$bits(in_item_t)-1:0];
		if (p < 45)
			c.operation = OP_WRITE;
		else if (p < 88)
			c.operation = OP_READ;
		else if (p < 94)
			c.operation = OP_CLEAR;
		else
			c.operation = OP_SPARE;
		if (q < 6)
			c.burst_length = 4'd0;
		else if (q < 12)
			c.burst_length = 4'($urandom_range(LANES + 1, 15));
		else
			c.burst_length = 4'($urandom_range(1, LANES));
		return c;
	endfunction

	task automatic check_field(string nm, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// wait until the block has nothing outstanding, then a short grace period
	task automatic settle();
		@(negedge clk);
		while (bursts_waiting.size() != 0 || start || reports_due.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	// capacity write also empties the ring
	task automatic write_capacity(logic [CAP_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cap_reg = v;
		wr_ptr = 0;
		rd_ptr = 0;
		ring_full = 1'b0;
	endtask

	task automatic random_phase(logic [CAP_W-1:0] cap_v, int unsigned n);
		write_capacity(cap_v);
		repeat (n)
			bursts_waiting.push_back(random_burst());
		settle();
	endtask

	// command driver: holds a presented command until busy lets it through
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy) begin
				reports_due.push_back(ring_apply(item));
				n_sent++;
			end
			no_gaps = (n_sent >= 200 && n_sent < 330);
			if (!(start && busy)) begin
				if (bursts_waiting.size() != 0
						&& (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
					start <= 1'b1;
					item <= bursts_waiting.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// report monitor: every strobe is a transfer, compared against the oldest due report
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reports_due.size() == 0) begin
				$display("%0t: report with none due, expected nothing actual %0h",
					$time, result);
				mismatch_count++;
			end else begin
				want = reports_due.pop_front();
				check_field("status", want.status, result.status);
				check_field("rdata_0", want.rdata_0, result.rdata_0);
				check_field("rdata_1", want.rdata_1, result.rdata_1);
				check_field("rdata_2", want.rdata_2, result.rdata_2);
				check_field("rdata_3", want.rdata_3, result.rdata_3);
				check_field("rdata_4", want.rdata_4, result.rdata_4);
				check_field("rdata_5", want.rdata_5, result.rdata_5);
				check_field("rdata_6", want.rdata_6, result.rdata_6);
				check_field("rdata_7", want.rdata_7, result.rdata_7);
				check_field("fill_level", want.fill_level, result.fill_level);
				check_field("free_space", want.free_space, result.free_space);
			end
		end
	end

	// watchdog: any transfer on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		foreach (ring_mem[i])
			ring_mem[i] = '0;
		wr_ptr = 0;
		rd_ptr = 0;
		ring_full = 1'b0;
		cap_reg = CAP_W'(RING_DEPTH);
		n_sent = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset capacity: empty-ring refusals, no-op forms, saturating length
		bursts_waiting.push_back(make_burst(OP_READ, 4'd1, 8'h00));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd0, 8'h5A));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd0, 8'h00));
		bursts_waiting.push_back(make_burst(OP_SPARE, 4'd8, 8'hFF));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd8, 8'h00));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd15, 8'hFF));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd15, 8'h00));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd3, 8'h00));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd5, 8'h00));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd1, 8'h00));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd4, 8'hA5));
		bursts_waiting.push_back(make_burst(OP_CLEAR, 4'd0, 8'h00));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd1, 8'h00));
		settle();

		// eight slots: fill to full, refuse on full, wrap both pointers
		write_capacity(13'd8);
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd8, 8'h3C));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd1, 8'h99));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd2, 8'h00));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd3, 8'hC3));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd2, 8'hE1));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd8, 8'h00));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd5, 8'h7E));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd5, 8'h00));
		settle();

		// capacity zero behaves as a single slot
		write_capacity(13'd0);
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd1, 8'h81));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd1, 8'h18));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd1, 8'h00));
		bursts_waiting.push_back(make_burst(OP_READ, 4'd1, 8'h00));
		bursts_waiting.push_back(make_burst(OP_WRITE, 4'd2, 8'h42));
		settle();

		// random traffic over a spread of capacities, extremes included
		random_phase(13'd1, 40);
		random_phase(13'd2, 40);
		random_phase(13'd3, 40);
		random_phase(13'd5, 40);
		random_phase(13'd8, 45);
		random_phase(13'd9, 45);
		random_phase(13'd13, 45);
		random_phase(13'd4096, 40);
		random_phase(13'd8191, 30);
		random_phase(13'd4097, 30);
		random_phase(13'($urandom_range(1, 64)), 45);
		random_phase(13'($urandom_range(0, 8191)), 40);

		// let any stray strobe show up before the verdict
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
